FILE: sv/mefa_pkg.sv
// Shared format codes and constants for the multi-format elementwise adder.
package mefa_pkg;

  localparam logic [1:0] FMT_FP32  = 2'd0;
  localparam logic [1:0] FMT_BF16  = 2'd1;
  localparam logic [1:0] FMT_INT32 = 2'd2;
  localparam logic [1:0] FMT_INT8  = 2'd3;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7FC0;
  localparam logic [31:0] INF32  = 32'h7F80_0000;

  localparam logic signed [8:0] INT8_MIN = -9'sd128;
  localparam logic signed [8:0] INT8_MAX = 9'sd127;

endpackage

FILE: sv/mefa_fp_add.sv
// Combinational IEEE single-precision add with round-to-nearest-even.
module mefa_fp_add
  import mefa_pkg::*;
(
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] sum
);

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic        x_nan, y_nan, x_inf, y_inf;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [23:0] mb, ms;
  logic [31:0] wa, wb, wb_sh;
  logic [32:0] s0;
  logic [31:0] s1, s2;
  logic [8:0]  e1, e2, e3;
  logic [5:0]  lz;
  logic [8:0]  shamt;
  logic [23:0] mant;
  logic [7:0]  rem;
  logic        rnd_up;
  logic [24:0] mant_r;
  logic [23:0] mant_f;

  always_comb begin
    x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf = (x[30:0] == INF32[30:0]);
    y_inf = (y[30:0] == INF32[30:0]);

    if (x[30:0] >= y[30:0]) begin
      big = x;
      sml = y;
    end else begin
      big = y;
      sml = x;
    end

    eb = (big[30:23] != 8'd0) ? big[30:23] : 8'd1;
    es = (sml[30:23] != 8'd0) ? sml[30:23] : 8'd1;
    mb = {big[30:23] != 8'd0, big[22:0]};
    ms = {sml[30:23] != 8'd0, sml[22:0]};
    wa = {mb, 8'd0};
    wb = {ms, 8'd0};
    d  = eb - es;

    // Align the smaller operand; shifted-out bits fold into a sticky bit.
    if (d >= 8'd32) begin
      wb_sh = {31'd0, wb != 32'd0};
    end else begin
      wb_sh = (wb >> d[4:0]) | {31'd0, ((wb >> d[4:0]) << d[4:0]) != wb};
    end

    if (big[31] == sml[31]) s0 = {1'b0, wa} + {1'b0, wb_sh};
    else                    s0 = {1'b0, wa} - {1'b0, wb_sh};

    if (s0[32]) begin
      s1 = s0[32:1] | {31'd0, s0[0]};
      e1 = {1'b0, eb} + 9'd1;
    end else begin
      s1 = s0[31:0];
      e1 = {1'b0, eb};
    end

    // Normalize left, but stop at the subnormal exponent.
    lz    = lzc32(s1);
    shamt = ({3'd0, lz} < (e1 - 9'd1)) ? {3'd0, lz} : (e1 - 9'd1);
    s2    = s1 << shamt[5:0];
    e2    = e1 - shamt;

    mant   = s2[31:8];
    rem    = s2[7:0];
    rnd_up = (rem > 8'h80) || ((rem == 8'h80) && mant[0]);
    mant_r = {1'b0, mant} + {24'd0, rnd_up};
    if (mant_r[24]) begin
      mant_f = mant_r[24:1];
      e3     = e2 + 9'd1;
    end else begin
      mant_f = mant_r[23:0];
      e3     = e2;
    end

    priority if (x_nan || y_nan) begin
      sum = QNAN32;
    end else if (x_inf && y_inf) begin
      sum = (x[31] != y[31]) ? QNAN32 : x;
    end else if (x_inf) begin
      sum = x;
    end else if (y_inf) begin
      sum = y;
    end else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) begin
      sum = {x[31] & y[31], 31'd0};
    end else if (s0 == 33'd0) begin
      sum = 32'd0;
    end else if (e3 >= 9'd255) begin
      sum = {big[31], INF32[30:0]};
    end else begin
      sum = {big[31], (mant_f[23] ? e3[7:0] : 8'd0), mant_f[22:0]};
    end
  end

endmodule

FILE: sv/multi_format_elementwise_adder_core.sv
// Top level: stream-in, two-register pipeline, multi-format add, stream-out.
//
// Usage: each slave-side transaction carries two operands as raw bits; one
// master-side transaction returns their sum in the format held in the
// number_format register (0 FP32, 1 BF16, 2 INT32 wrapping, 3 INT8
// saturating). Narrow formats use the low bits of each operand and return
// zeros above the format width.
// An accepted item passes through the input register, then the result
// register, with the add logic between.
// Throughput: one item per cycle while the receiver keeps tready high; the
// add logic between the two registers is combinational.
// The input register accepts a new item whenever it is empty or can move on,
// so an item can enter while a finished result waits to be taken. When the
// receiver holds tready low, both registers fill and s_tready drops after
// two items; no result is lost or repeated.
// Reset (rst, synchronous, active high) empties both registers and sets
// number_format to FP32. Write number_format over APB only while idle.
module multi_format_elementwise_adder_core
  import mefa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // a_bits [31:0], b_bits [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sum_bits [31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  number_format;
  logic        in_valid;
  logic [31:0] a_reg, b_reg;
  logic        out_free, in_free;
  logic [31:0] fa_x, fa_y, fa_sum;
  logic [31:0] sum_next;
  logic        cfg_write;
  logic [31:0] bf_round;
  logic signed [8:0] i8_sum;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == 1'b0) ? {30'd0, number_format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= FMT_FP32;
    end else if (cfg_write && paddr[2] == 1'b0) begin
      number_format <= pwdata[1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign in_free  = !in_valid || out_free;
  assign s_tready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_tvalid) begin
      a_reg <= s_tdata[31:0];
      b_reg <= s_tdata[63:32];
    end
  end

  always_comb begin
    if (number_format == FMT_BF16) begin
      fa_x = {a_reg[15:0], 16'd0};
      fa_y = {b_reg[15:0], 16'd0};
    end else begin
      fa_x = a_reg;
      fa_y = b_reg;
    end
  end

  mefa_fp_add u_fp_add (
    .x   (fa_x),
    .y   (fa_y),
    .sum (fa_sum)
  );

  always_comb begin
    bf_round = fa_sum + 32'h0000_7FFF + {31'd0, fa_sum[16]};
    i8_sum   = {a_reg[7], a_reg[7:0]} + {b_reg[7], b_reg[7:0]};
    unique case (number_format)
      FMT_FP32:  sum_next = fa_sum;
      FMT_BF16:  sum_next = (fa_sum == QNAN32) ? {16'd0, QNAN16} : {16'd0, bf_round[31:16]};
      FMT_INT32: sum_next = a_reg + b_reg;
      FMT_INT8: begin
        if (i8_sum > INT8_MAX)      sum_next = {24'd0, INT8_MAX[7:0]};
        else if (i8_sum < INT8_MIN) sum_next = {24'd0, INT8_MIN[7:0]};
        else                        sum_next = {24'd0, i8_sum[7:0]};
      end
      default:   sum_next = fa_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      m_tdata <= sum_next;
    end
  end

  // Held item in the input register stays while the output is blocked.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(a_reg) && $stable(b_reg))
    else $error("input register lost an item under stall");

  // An accepted transaction lands in the input register.
  a_in_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted transaction not captured");

  // A filled input register moves to the result register when it is free.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_free |=> m_tvalid)
    else $error("result not produced");

endmodule

FILE: sim/multi_format_elementwise_adder_core_test.sv
// Testbench for the multi-format elementwise adder: random stream traffic checked against a predictor.
module multi_format_elementwise_adder_core_test;
  import mefa_pkg::*;

  // Bit-exact model of the adder for each format, with its own format register copy.
  class sum_scoreboard;
    logic [1:0] fmt;
    logic [31:0] pending_sums[$];
    int mismatches;
    int checked;

    function new();
      fmt = FMT_FP32;
      mismatches = 0;
      checked = 0;
    endfunction

    function bit nan32(logic [31:0] v);
      return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function bit inf32(logic [31:0] v);
      return v[30:0] == INF32[30:0];
    endfunction

    function logic [31:0] single_add(logic [31:0] x, logic [31:0] y);
      logic [31:0] big, sml, sgn, eb, es, mb, ms, e, mant, rem;
      logic [63:0] wa, wb, s, lost;
      int d;
      if (nan32(x) || nan32(y)) return QNAN32;
      if (inf32(x) && inf32(y)) return ((x ^ y) & 32'h8000_0000) != 0 ? QNAN32 : x;
      if (inf32(x)) return x;
      if (inf32(y)) return y;
      if (x[30:0] == 0 && y[30:0] == 0) return x & y & 32'h8000_0000;
      if (x[30:0] >= y[30:0]) begin
        big = x; sml = y;
      end else begin
        big = y; sml = x;
      end
      sgn = big & 32'h8000_0000;
      eb = big[30:23]; es = sml[30:23];
      mb = big[22:0]; ms = sml[22:0];
      if (eb != 0) mb |= 32'h80_0000; else eb = 1;
      if (es != 0) ms |= 32'h80_0000; else es = 1;
      wa = 64'(mb) << 8;
      wb = 64'(ms) << 8;
      d = int'(eb) - int'(es);
      if (d >= 40) begin
        wb = wb != 0 ? 1 : 0;
      end else if (d > 0) begin
        lost = wb & ((64'd1 << d) - 1);
        wb = (wb >> d) | (lost != 0 ? 1 : 0);
      end
      s = (big[31] == sml[31]) ? wa + wb : wa - wb;
      if (s == 0) return 0;
      e = eb;
      if (s >= (64'd1 << 32)) begin
        s = (s >> 1) | (s & 1);
        e++;
      end
      while (s < (64'd1 << 31) && e > 1) begin
        s <<= 1;
        e--;
      end
      mant = s[39:8];
      rem = s[7:0];
      if (rem > 128 || (rem == 128 && mant[0])) mant++;
      if (mant >= 32'h100_0000) begin
        mant >>= 1;
        e++;
      end
      if (e >= 255) return sgn | INF32;
      return sgn | ((mant[23] ? e : 0) << 23) | (mant & 32'h7F_FFFF);
    endfunction

    function logic [31:0] element_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      int s8;
      case (fmt)
        FMT_FP32: begin
          r = single_add(a, b);
          if (nan32(r)) r = QNAN32;
        end
        FMT_BF16: begin
          r = single_add({a[15:0], 16'h0}, {b[15:0], 16'h0});
          if (nan32(r)) begin
            r = {16'h0, QNAN16};
          end else begin
            r = r + 32'h7FFF + r[16];
            r = {16'h0, r[31:16]};
          end
        end
        FMT_INT32: r = a + b;
        default: begin
          s8 = int'($signed(a[7:0])) + int'($signed(b[7:0]));
          if (s8 > INT8_MAX) s8 = INT8_MAX;
          if (s8 < INT8_MIN) s8 = INT8_MIN;
          r = {24'h0, 8'(s8)};
        end
      endcase
      return r;
    endfunction

    function void note_operands(logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(element_sum(a, b));
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      checked++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sum %h", got);
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("fmt %0d sum_bits: expected %h got %h", fmt, want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [63:0] s_tdata;   // a_bits [31:0], b_bits [63:32]
  logic [31:0] m_tdata;   // sum_bits [31:0]
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic stall_long;
  int cycles;
  sum_scoreboard sb;

  multi_format_elementwise_adder_core i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Receiver: random stalls of random length, held ready during bursts.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_tready = 0;
    stall_long = 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_sum(m_tdata);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (!stall_long && $urandom_range(0, 2) == 0) begin
        hold_cnt = gap_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout");
        $display("multi_format_elementwise_adder_core_test: done, errors");
        $finish;
      end
    end
  end

  task automatic write_format(logic [31:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk iff pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.fmt = value[1:0];
  endtask

  // Hold tvalid across back-to-back transactions; drop it only for a gap.
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int g;
    g = stall_long ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {b, a};
    @(posedge clk iff s_tready);
    sb.note_operands(a, b);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Operand biased toward the interesting encodings of each format.
  function logic [31:0] pick_operand(logic [1:0] f);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'hFE;
      3: v[30:23] = 8'(126 + $urandom_range(0, 3));
      default: ;
    endcase
    if (f == FMT_BF16) begin
      v[15:0] = v[31:16];
      if ($urandom_range(0, 1)) v[31:16] = $urandom;
    end
    return v;
  endfunction

  logic [31:0] dir_vals[12] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
    32'h0000_7F80, 32'h0000_FF7F, 32'h0000_0080};
  logic [31:0] fmt_vals[6] = '{32'd1, 32'd2, 32'd3, 32'hFFFF_FFFC, 32'd0, 32'h5};

  initial begin
    logic [31:0] a;
    sb = new();
    rst = 1;
    s_tvalid = 0; s_tdata = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Reset format is FP32: specials, overflow, cancellation, signed zeros.
    send_pair(32'h7F80_0000, 32'hFF80_0000);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h3F80_0000, 32'hBF80_0000);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_pair(32'h0000_0001, 32'h807F_FFFF);
    send_pair(32'h7FC0_0001, 32'h3F80_0000);
    send_pair(32'h4B80_0000, 32'h3F80_0001);
    drain();
    for (int f = 0; f < 6; f++) begin
      write_format(fmt_vals[f]);
      for (int k = 0; k < 3; k++)
        send_pair(dir_vals[$urandom_range(0, 11)], dir_vals[$urandom_range(0, 11)]);
      for (int k = 0; k < 100; k++) begin
        stall_long = (k >= 40 && k < 55);
        if (sb.fmt == FMT_INT8 && $urandom_range(0, 3) == 0) begin
          a = $urandom;
          a[7:0] = 8'h7F;
          send_pair(a, $urandom);
        end else begin
          send_pair(pick_operand(sb.fmt), pick_operand(sb.fmt));
        end
      end
      stall_long = 0;
      drain();
    end
    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d sums across FP32, BF16, INT32 and INT8, incl. special encodings",
             sb.checked);
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0)
      $display("multi_format_elementwise_adder_core_test: done, clean");
    else
      $display("multi_format_elementwise_adder_core_test: done, errors");
    $finish;
  end
endmodule
